### hw/rtl/rpsa_pkg.sv
package rpsa_pkg;

	localparam int PART_BITS_MAX = 10;
	localparam int COUNT_WIDTH   = 24;
	localparam int KEY_WIDTH     = 32;
	localparam int CFG_WIDTH     = 4;
	localparam int TABLE_DEPTH   = 1 << PART_BITS_MAX;

	localparam logic [CFG_WIDTH-1:0]   PART_BITS_RESET = CFG_WIDTH'(4);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX       = {COUNT_WIDTH{1'b1}};

	// transaction modes
	localparam logic [1:0] MODE_COUNT = 2'd0;
	localparam logic [1:0] MODE_PLACE = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]           mode;
		logic [KEY_WIDTH-1:0] key;
	} rpsa_item_t;

	typedef struct packed {
		logic [PART_BITS_MAX-1:0] partition;
		logic [COUNT_WIDTH-1:0]   position;
		logic                     status;
	} rpsa_result_t;

	// table update decided for one transaction
	typedef struct packed {
		logic                   we;
		logic [COUNT_WIDTH-1:0] wdata;
		rpsa_result_t           res;
	} rpsa_upd_t;

endpackage

### hw/rtl/radix_partition_slot_assigner_unit.sv
// Radix partition slot assigner: histogram, exclusive prefix sum and scatter slot
// assignment for one relation, with the 1024 x 24-bit count/slot table held in
// one dual-port RAM (one write port, one registered read port). A count
// transaction bumps the count of partition key & (2^partition_bits - 1); the
// first place transaction after counting walks the active partitions once,
// turning counts into start offsets, and every place transaction then returns
// its partition and destination slot and advances the slot. Counts and slots
// saturate at 2^24 - 1 with status set; a count after the offset walk leaves
// the table alone. A transaction is taken in the idle state and finished in
// the execute state, which waits while the result side stalls, and no new one
// is taken before then, as the single table read port does a read-modify-write.
// The first place after counting adds the offset walk: one entry per cycle
// through the read and write ports, then the write-back of the last entry,
// then the fetch of the place transaction's own entry. After reset and after
// each clear transaction the block clears all 1024 table entries before it
// takes the next one. partition_bits (cfg_data) is to be written only while the
// block is idle, which the block does not enforce; 0 acts as 1, above 10 as 10.
module radix_partition_slot_assigner_unit import rpsa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// item channel
	input  logic                 item_valid,
	output logic                 item_stall,
	input  rpsa_item_t           item,
	// result channel
	output logic                 result_valid,
	input  logic                 result_stall,
	output rpsa_result_t         result,
	// configuration write
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_WIDTH-1:0] cfg_data
);

	localparam int AW = PART_BITS_MAX;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_PFX,
		S_EXEC
	} state_t;

	state_t state_q;

	logic [CFG_WIDTH-1:0]   part_bits_q;
	logic                   offsets_q;
	logic [COUNT_WIDTH-1:0] total_q;
	logic [AW-1:0]          clr_idx_q;
	logic [AW:0]            rd_idx_q;
	logic                   pend_s1;
	logic [AW-1:0]          widx_s1;
	logic [1:0]             mode_s1;
	logic [AW-1:0]          part_s1;
	logic                   result_valid_q;
	rpsa_result_t           result_q;

	logic [AW-1:0]          part_mask;
	logic [AW:0]            part_count;
	logic [AW-1:0]          item_part;
	logic                   item_accept;
	logic                   out_free;
	logic                   walk_more;
	logic                   walk_done;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata;

	rpsa_upd_t              upd;

	// clamp partition_bits to 1..PART_BITS_MAX and build the low-bit mask
	function automatic logic [AW-1:0] active_mask(input logic [CFG_WIDTH-1:0] pb);
		logic [CFG_WIDTH-1:0] b;
		b = pb;
		if (pb == '0) begin
			b = CFG_WIDTH'(1);
		end else if (pb > CFG_WIDTH'(PART_BITS_MAX)) begin
			b = CFG_WIDTH'(PART_BITS_MAX);
		end
		return ~({AW{1'b1}} << b);
	endfunction

	assign part_mask   = active_mask(part_bits_q);
	assign part_count  = {1'b0, part_mask} + (AW+1)'(1);
	assign item_part   = item.key[AW-1:0] & part_mask;

	assign item_stall  = (state_q != S_IDLE);
	assign item_accept = item_valid && !item_stall;
	assign cfg_ready   = 1'b1;

	assign result_valid = result_valid_q;
	assign result       = result_q;
	// output register can take a new result this cycle
	assign out_free     = !result_valid_q || !result_stall;

	// offset walk: read entry i while the entry read last cycle is written back
	assign walk_more = (rd_idx_q < part_count);
	assign walk_done = !walk_more && !pend_s1;

	rpsa_update u_update (
		.mode          (mode_s1),
		.partition     (part_s1),
		.entry         (ram_rdata),
		.offsets_ready (offsets_q),
		.upd           (upd)
	);

	rpsa_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// table port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
			end
			S_IDLE: begin
				ram_re    = item_accept;
				ram_raddr = item_part;
			end
			S_PFX: begin
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = widx_s1;
					ram_wdata = total_q;
				end
				if (walk_more) begin
					ram_re    = 1'b1;
					ram_raddr = rd_idx_q[AW-1:0];
				end else if (!pend_s1) begin
					// walk finished: fetch the place transaction's own entry
					ram_re    = 1'b1;
					ram_raddr = part_s1;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					ram_we    = upd.we;
					ram_waddr = part_s1;
					ram_wdata = upd.wdata;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			part_bits_q    <= PART_BITS_RESET;
			offsets_q      <= 1'b0;
			total_q        <= '0;
			clr_idx_q      <= '0;
			rd_idx_q       <= '0;
			pend_s1        <= 1'b0;
			widx_s1        <= '0;
			mode_s1        <= MODE_COUNT;
			part_s1        <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				part_bits_q <= cfg_data;
			end

			// load a new result from the execute step, else drop a taken one
			if (state_q == S_EXEC && out_free) begin
				result_valid_q <= 1'b1;
				result_q       <= upd.res;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					if (clr_idx_q == {AW{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_accept) begin
						mode_s1 <= item.mode;
						part_s1 <= item_part;
						if (item.mode == MODE_PLACE && !offsets_q) begin
							state_q  <= S_PFX;
							rd_idx_q <= '0;
							pend_s1  <= 1'b0;
							total_q  <= '0;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_PFX: begin
					// saturating running total of the counts read back
					if (pend_s1) begin
						if (ram_rdata >= COUNT_MAX - total_q) begin
							total_q <= COUNT_MAX;
						end else begin
							total_q <= total_q + ram_rdata;
						end
					end
					pend_s1 <= walk_more;
					widx_s1 <= rd_idx_q[AW-1:0];
					if (walk_more) begin
						rd_idx_q <= rd_idx_q + (AW+1)'(1);
					end
					if (walk_done) begin
						offsets_q <= 1'b1;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						if (mode_s1 == MODE_CLEAR) begin
							state_q   <= S_CLEAR;
							clr_idx_q <= '0;
							offsets_q <= 1'b0;
							total_q   <= '0;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// no read and write of the same entry in one cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re && ram_we |-> ram_raddr != ram_waddr)
		else $error("table read and write hit the same entry");

	// offsets become ready only at the end of a walk
	a_offsets_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(offsets_q) |-> $past(state_q == S_PFX))
		else $error("offsets_ready set outside the offset walk");

	// an accepted transaction always moves the controller out of idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_accept |=> state_q != S_IDLE)
		else $error("accepted transaction not taken up");

	// a result is loaded only from the execute step
	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == S_EXEC))
		else $error("result produced outside execute step");

endmodule

### hw/rtl/rpsa_ram.sv
module rpsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/rpsa_update.sv
module rpsa_update import rpsa_pkg::*; (
	input  logic [1:0]               mode,
	input  logic [PART_BITS_MAX-1:0] partition,
	input  logic [COUNT_WIDTH-1:0]   entry,
	input  logic                     offsets_ready,
	output rpsa_upd_t                upd
);

	logic at_max;
	logic [COUNT_WIDTH-1:0] entry_inc;

	assign at_max    = (entry == COUNT_MAX);
	assign entry_inc = entry + COUNT_WIDTH'(1);

	always_comb begin
		upd = '0;
		case (mode)
			MODE_COUNT: begin
				upd.res.partition = partition;
				// counting while placing leaves the table alone
				if (!offsets_ready) begin
					if (at_max) begin
						upd.res.position = COUNT_MAX;
						upd.res.status   = 1'b1;
					end else begin
						upd.we           = 1'b1;
						upd.wdata        = entry_inc;
						upd.res.position = entry_inc;
					end
				end
			end
			MODE_PLACE: begin
				upd.res.partition = partition;
				if (at_max) begin
					upd.res.position = COUNT_MAX;
					upd.res.status   = 1'b1;
				end else begin
					upd.we           = 1'b1;
					upd.wdata        = entry_inc;
					upd.res.position = entry;
				end
			end
			default: begin
				upd = '0;
			end
		endcase
	end

endmodule
